/* hdl/vc2d_pkg.sv */
// shared types and constants for the 2d valid correlation block
package vc2d_pkg;

  localparam int unsigned SUM_W      = 40;
  localparam int unsigned ROWS_W     = 13;
  localparam int unsigned ROW_CNT_W  = 12;
  localparam int unsigned ROWS_LIMIT = 4096;
  localparam int unsigned COLS_REG_W = 7;
  localparam int unsigned KERN_REG_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

  localparam logic [ROWS_W-1:0]     IMAGE_ROWS_RST  = 13'd28;
  localparam logic [COLS_REG_W-1:0] IMAGE_COLS_RST  = 7'd28;
  localparam logic [KERN_REG_W-1:0] KERNEL_ROWS_RST = 3'd3;
  localparam logic [KERN_REG_W-1:0] KERNEL_COLS_RST = 3'd3;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_TDIV  = 6'b000100,
    S_MAC   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

endpackage

/* hdl/vc2d_item_if.sv */
// input word channel: kernel tap or image sample
interface vc2d_item_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

/* hdl/vc2d_result_if.sv */
// output word channel: window sum and end of frame flag
interface vc2d_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [vc2d_pkg::SUM_W-1:0] sum;
  logic                             last;

  modport source (output valid, sum, last, input ready);
  modport sink   (input valid, sum, last, output ready);
endinterface

/* hdl/vc2d_line_mem.sv */
// line store memory, one write and one registered read port
module vc2d_line_mem #(
  parameter int unsigned DEPTH  = 320,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/vc2d_mac.sv */
// shared multiply-accumulate unit, registered product and accumulator
module vc2d_mac #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vc2d_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]     a_i,
  input  logic signed [SAMPLE_BITS-1:0]     b_i,
  output logic signed [vc2d_pkg::SUM_W-1:0] acc_o
);

  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;

  vc2d_pkg::mac_ctrl_t              ctrl_q;
  logic signed [PROD_W-1:0]         prod_d, prod_q;
  logic signed [vc2d_pkg::SUM_W-1:0] prod_ext, acc_q;

  assign prod_d   = a_i * b_i;
  assign prod_ext = vc2d_pkg::SUM_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
    if (ctrl_q.en) begin
      acc_q <= ctrl_q.clr ? prod_ext : acc_q + prod_ext;
    end
  end

  assign acc_o = acc_q;

endmodule

/* hdl/valid_correlation_2d.sv */
// top level of the 2d valid correlation block
// Words with mode 0 load the next kernel tap in row-major order, words with mode 1 are image
// samples in raster order. A mode 1 word that completes a kernel_rows x kernel_cols window
// yields one output word holding the exact 40-bit sum of tap times sample products, with last
// set on the final window of the frame. One word is worked on at a time; ready is high only
// while the sequencer is idle. A sample that completes a window makes one pass of the shared
// multiply-accumulate unit per tap, with setup before and pipeline drain after; other samples
// are only written into the line store. A tap load splits the tap index into row and column
// by repeated subtraction. The output register lets the next word be taken while a result
// waits to be read.
module valid_correlation_2d #(
  parameter int unsigned MAX_KERNEL  = 5,
  parameter int unsigned MAX_WIDTH   = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [vc2d_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [vc2d_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  vc2d_item_if.sink                             in_i,
  vc2d_result_if.source                         out_o
);

  localparam int unsigned SLOT_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned KC_W    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned TAPN_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int unsigned NTAPS   = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned TAPA_W  = (NTAPS > 1) ? $clog2(NTAPS) : 1;
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned COLN_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DEPTH   = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned MEMA_W  = $clog2(DEPTH);
  localparam int unsigned ROW_W   = vc2d_pkg::ROW_CNT_W;
  localparam int unsigned ROWS_W  = vc2d_pkg::ROWS_W;

  // configuration registers
  logic [ROWS_W-1:0]                   cfg_rows_q;
  logic [vc2d_pkg::COLS_REG_W-1:0]     cfg_cols_q;
  logic [vc2d_pkg::KERN_REG_W-1:0]     cfg_kr_q, cfg_kc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows_q <= vc2d_pkg::IMAGE_ROWS_RST;
      cfg_cols_q <= vc2d_pkg::IMAGE_COLS_RST;
      cfg_kr_q   <= vc2d_pkg::KERNEL_ROWS_RST;
      cfg_kc_q   <= vc2d_pkg::KERNEL_COLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vc2d_pkg::CFG_IMAGE_ROWS:  cfg_rows_q <= cfg_data_i[ROWS_W-1:0];
        vc2d_pkg::CFG_IMAGE_COLS:  cfg_cols_q <= cfg_data_i[vc2d_pkg::COLS_REG_W-1:0];
        vc2d_pkg::CFG_KERNEL_ROWS: cfg_kr_q   <= cfg_data_i[vc2d_pkg::KERN_REG_W-1:0];
        vc2d_pkg::CFG_KERNEL_COLS: cfg_kc_q   <= cfg_data_i[vc2d_pkg::KERN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [ROWS_W-1:0] rows_eff;
  logic [COLN_W-1:0] cols_eff;
  logic [KC_W-1:0]   kr_eff, kc_eff;
  logic [TAPN_W-1:0] ntaps;

  always_comb begin
    if (cfg_rows_q == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (int'(cfg_rows_q) > vc2d_pkg::ROWS_LIMIT) begin
      rows_eff = ROWS_W'(vc2d_pkg::ROWS_LIMIT);
    end else begin
      rows_eff = cfg_rows_q;
    end
    if (cfg_cols_q == '0) begin
      cols_eff = COLN_W'(1);
    end else if (int'(cfg_cols_q) > MAX_WIDTH) begin
      cols_eff = COLN_W'(MAX_WIDTH);
    end else begin
      cols_eff = COLN_W'(cfg_cols_q);
    end
    if (cfg_kr_q == '0) begin
      kr_eff = KC_W'(1);
    end else if (int'(cfg_kr_q) > MAX_KERNEL) begin
      kr_eff = KC_W'(MAX_KERNEL);
    end else begin
      kr_eff = KC_W'(cfg_kr_q);
    end
    if (cfg_kc_q == '0) begin
      kc_eff = KC_W'(1);
    end else if (int'(cfg_kc_q) > MAX_KERNEL) begin
      kc_eff = KC_W'(MAX_KERNEL);
    end else begin
      kc_eff = KC_W'(cfg_kc_q);
    end
    ntaps = TAPN_W'(kr_eff) * TAPN_W'(kc_eff);
  end

  // sequencer state
  vc2d_pkg::state_e                 state_q;
  logic                             mode_q;
  logic signed [SAMPLE_BITS-1:0]    value_q;
  logic [TAPN_W-1:0]                tidx_q, rem_q;
  logic [SLOT_W-1:0]                trow_q;
  logic [COL_W-1:0]                 col_q, col0_q;
  logic [ROW_W-1:0]                 row_q;
  logic [SLOT_W-1:0]                slot_q, k_q, l_q, ms_q;
  logic                             wlast_q, drain_q;
  vc2d_pkg::mac_ctrl_t              issue_q;
  logic                             out_valid_q, out_last_q;
  logic signed [vc2d_pkg::SUM_W-1:0] out_sum_q;
  logic signed [SAMPLE_BITS-1:0]    taps_q [NTAPS];
  logic signed [SAMPLE_BITS-1:0]    tap_rd_q;

  // effective counters and window setup
  logic [COL_W-1:0]  c_eff, c_next, col0_d;
  logic [ROW_W-1:0]  r_eff, r_next;
  logic [SLOT_W-1:0] s_eff, s_next, ws;
  logic [KC_W:0]     ws_tmp;
  logic [TAPN_W-1:0] tidx_eff, tidx_inc;
  logic              col_wrap, row_wrap, window, is_last;
  logic              l_end, k_end, ms_wrap, rem_ge;
  logic              accept, out_load;

  always_comb begin
    c_eff    = (COLN_W'(col_q) >= cols_eff) ? '0 : col_q;
    r_eff    = ({1'b0, row_q} >= rows_eff) ? '0 : row_q;
    s_eff    = ({1'b0, row_q} >= rows_eff) ? '0 : slot_q;
    tidx_eff = (tidx_q >= ntaps) ? '0 : tidx_q;
    tidx_inc = tidx_q + TAPN_W'(1);

    col_wrap = (COLN_W'(c_eff) + COLN_W'(1)) >= cols_eff;
    row_wrap = ({1'b0, r_eff} + ROWS_W'(1)) >= rows_eff;
    c_next   = col_wrap ? '0 : c_eff + COL_W'(1);
    r_next   = r_eff;
    s_next   = s_eff;
    if (col_wrap) begin
      if (row_wrap) begin
        r_next = '0;
        s_next = '0;
      end else begin
        r_next = r_eff + ROW_W'(1);
        s_next = (KC_W'(s_eff) + KC_W'(1) == KC_W'(MAX_KERNEL)) ? '0 : s_eff + SLOT_W'(1);
      end
    end

    window  = (({1'b0, r_eff} + ROWS_W'(1)) >= ROWS_W'(kr_eff)) &&
              ((COLN_W'(c_eff) + COLN_W'(1)) >= COLN_W'(kc_eff));
    is_last = ({1'b0, r_eff} == rows_eff - ROWS_W'(1)) &&
              (COLN_W'(c_eff) == cols_eff - COLN_W'(1));
    col0_d  = COL_W'(COLN_W'(c_eff) + COLN_W'(1) - COLN_W'(kc_eff));

    if ((KC_W + 1)'(s_eff) >= (KC_W + 1)'(kr_eff - KC_W'(1))) begin
      ws_tmp = (KC_W + 1)'(s_eff) - (KC_W + 1)'(kr_eff - KC_W'(1));
    end else begin
      ws_tmp = (KC_W + 1)'(s_eff) + (KC_W + 1)'(MAX_KERNEL) - (KC_W + 1)'(kr_eff - KC_W'(1));
    end
    ws = SLOT_W'(ws_tmp);

    l_end   = (KC_W'(l_q) + KC_W'(1)) == kc_eff;
    k_end   = (KC_W'(k_q) + KC_W'(1)) == kr_eff;
    ms_wrap = (KC_W'(ms_q) + KC_W'(1)) == KC_W'(MAX_KERNEL);
    rem_ge  = rem_q >= TAPN_W'(kc_eff);
  end

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == vc2d_pkg::S_IDLE);
  assign out_load = (state_q == vc2d_pkg::S_DONE) && (!out_valid_q || out_o.ready);

  // memory and tap addressing
  logic                    mem_we;
  logic [MEMA_W-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0]  mem_rdata;
  logic [TAPA_W-1:0]       tap_raddr, tap_waddr;
  logic                    tap_we;

  assign mem_we    = (state_q == vc2d_pkg::S_PREP) && mode_q;
  assign mem_waddr = MEMA_W'(s_eff) * MEMA_W'(MAX_WIDTH) + MEMA_W'(c_eff);
  assign mem_raddr = MEMA_W'(ms_q) * MEMA_W'(MAX_WIDTH) + MEMA_W'(col0_q) + MEMA_W'(l_q);
  assign tap_raddr = TAPA_W'(k_q) * TAPA_W'(MAX_KERNEL) + TAPA_W'(l_q);
  assign tap_waddr = TAPA_W'(trow_q) * TAPA_W'(MAX_KERNEL) + TAPA_W'(rem_q);
  assign tap_we    = (state_q == vc2d_pkg::S_TDIV) && !rem_ge;

  vc2d_line_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (MEMA_W)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (value_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      taps_q[tap_waddr] <= value_q;
    end
    tap_rd_q <= taps_q[tap_raddr];
    if (accept) begin
      mode_q  <= in_i.mode;
      value_q <= in_i.value;
    end
  end

  logic signed [vc2d_pkg::SUM_W-1:0] acc;

  vc2d_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (issue_q),
    .a_i    (tap_rd_q),
    .b_i    ($signed(mem_rdata)),
    .acc_o  (acc)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vc2d_pkg::S_IDLE;
      tidx_q      <= '0;
      rem_q       <= '0;
      trow_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      col0_q      <= '0;
      k_q         <= '0;
      l_q         <= '0;
      ms_q        <= '0;
      wlast_q     <= 1'b0;
      drain_q     <= 1'b0;
      issue_q     <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_sum_q   <= '0;
    end else begin
      // one multiply-accumulate per tap, clear on the first
      issue_q <= {state_q == vc2d_pkg::S_MAC,
                  (state_q == vc2d_pkg::S_MAC) && (k_q == '0) && (l_q == '0)};
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_sum_q   <= acc;
        out_last_q  <= wlast_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        vc2d_pkg::S_IDLE: begin
          if (accept) begin
            state_q <= vc2d_pkg::S_PREP;
          end
        end
        vc2d_pkg::S_PREP: begin
          if (!mode_q) begin
            tidx_q  <= tidx_eff;
            rem_q   <= tidx_eff;
            trow_q  <= '0;
            state_q <= vc2d_pkg::S_TDIV;
          end else begin
            col_q   <= c_next;
            row_q   <= r_next;
            slot_q  <= s_next;
            col0_q  <= col0_d;
            ms_q    <= ws;
            k_q     <= '0;
            l_q     <= '0;
            wlast_q <= is_last;
            state_q <= window ? vc2d_pkg::S_MAC : vc2d_pkg::S_IDLE;
          end
        end
        vc2d_pkg::S_TDIV: begin
          if (rem_ge) begin
            rem_q  <= rem_q - TAPN_W'(kc_eff);
            trow_q <= trow_q + SLOT_W'(1);
          end else begin
            tidx_q  <= (tidx_inc >= ntaps) ? '0 : tidx_inc;
            state_q <= vc2d_pkg::S_IDLE;
          end
        end
        vc2d_pkg::S_MAC: begin
          if (l_end) begin
            l_q  <= '0;
            k_q  <= k_q + SLOT_W'(1);
            ms_q <= ms_wrap ? '0 : ms_q + SLOT_W'(1);
            if (k_end) begin
              drain_q <= 1'b0;
              state_q <= vc2d_pkg::S_DRAIN;
            end
          end else begin
            l_q <= l_q + SLOT_W'(1);
          end
        end
        vc2d_pkg::S_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            state_q <= vc2d_pkg::S_DONE;
          end
        end
        vc2d_pkg::S_DONE: begin
          if (out_load) begin
            state_q <= vc2d_pkg::S_IDLE;
          end
        end
        default: state_q <= vc2d_pkg::S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.sum   = out_sum_q;
  assign out_o.last  = out_last_q;

endmodule
